@@ rtl/dlte_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// DHCP lease table package
// Shared codes and control structs for the lease table controller and datapath.
// -----------------------------------------------------------------------------
package dlte_pkg;

   localparam int MAC_W  = 48;
   localparam int ADDR_W = 32;
   localparam int CMD_W  = 3;
   localparam int VERD_W = 3;

   localparam logic [CMD_W-1:0] CMD_DISCOVER = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REQUEST  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ADD      = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd4;

   localparam logic [VERD_W-1:0] V_OFFER    = 3'd0;
   localparam logic [VERD_W-1:0] V_ACK      = 3'd1;
   localparam logic [VERD_W-1:0] V_NAK      = 3'd2;
   localparam logic [VERD_W-1:0] V_NOADDR   = 3'd3;
   localparam logic [VERD_W-1:0] V_DONE     = 3'd4;
   localparam logic [VERD_W-1:0] V_FULL     = 3'd5;
   localparam logic [VERD_W-1:0] V_NOTFOUND = 3'd6;

   localparam logic CSR_POOL_FIRST = 1'b0;
   localparam logic CSR_POOL_LAST  = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request word, start slot scan
      logic scan_step;  // advance slot scan
      logic walk_start; // start address probe
      logic probe_step; // advance probe scan
      logic next_addr;  // move to next candidate address
      logic commit;     // apply table update and latch result
   } ctrl_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_last;   // slot scan at final slot
      logic probe_last;  // probe scan at final slot
      logic probe_hit;   // candidate address seen held
      logic walk_end;    // walk must stop after this candidate
      logic need_walk;   // command needs expected address and mac not found
   } stat_type;

endpackage

@@ rtl/dlte_if.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Lease table channel interfaces
// Valid/ready channels for request, response and register writes.
// -----------------------------------------------------------------------------
interface dlte_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [47:0] client_mac;
   logic [31:0] wanted_addr;
   logic [31:0] cur_addr;
   modport source (output valid, cmd, client_mac, wanted_addr, cur_addr, input ready);
   modport sink   (input valid, cmd, client_mac, wanted_addr, cur_addr, output ready);
endinterface

interface dlte_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  verdict;
   logic [31:0] granted_addr;
   modport source (output valid, verdict, granted_addr, input ready);
   modport sink   (input valid, verdict, granted_addr, output ready);
endinterface

interface dlte_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/dlte_ctrl.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Lease table controller
// Sequences slot scan, pool walk, commit and response handoff.
// -----------------------------------------------------------------------------
module dlte_ctrl
   import dlte_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output ctrl_type ctrl
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SCAN   = 6'b000010,
      S_PROBE  = 6'b000100,
      S_NEXT   = 6'b001000,
      S_COMMIT = 6'b010000,
      S_RESP   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.load = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            ctrl.scan_step = 1'b1;
            if (stat.scan_last) begin
               if (stat.need_walk) begin
                  ctrl.walk_start = 1'b1;
                  state_in        = S_PROBE;
               end else begin
                  state_in = S_COMMIT;
               end
            end
         end
         S_PROBE: begin
            ctrl.probe_step = 1'b1;
            if (stat.probe_hit) begin
               // candidate held: stop or go to next address
               state_in = stat.walk_end ? S_COMMIT : S_NEXT;
            end else if (stat.probe_last) begin
               state_in = S_COMMIT;
            end
         end
         S_NEXT: begin
            ctrl.next_addr = 1'b1;
            state_in       = S_PROBE;
         end
         S_COMMIT: begin
            ctrl.commit = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

@@ rtl/dlte_dp.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Lease table datapath
// Lease storage, slot scan, pool walk and result registers.
// -----------------------------------------------------------------------------
module dlte_dp
   import dlte_pkg::*;
#(
   parameter int LEASE_SLOTS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  ctrl_type          ctrl,
   output stat_type          stat,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [MAC_W-1:0]  req_mac,
   input  logic [ADDR_W-1:0] req_wanted,
   input  logic [ADDR_W-1:0] req_caddr,
   input  logic [ADDR_W-1:0] pool_first,
   input  logic [ADDR_W-1:0] pool_last,
   output logic [VERD_W-1:0] rsp_verdict,
   output logic [ADDR_W-1:0] rsp_granted
);

   localparam int IW = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;
   localparam int NW = $clog2(LEASE_SLOTS + 2);

   // memories, read one slot a cycle
   logic [MAC_W-1:0]  mac_mem  [LEASE_SLOTS];
   logic [ADDR_W-1:0] addr_mem [LEASE_SLOTS];
   logic              fix_mem  [LEASE_SLOTS];
   logic [LEASE_SLOTS-1:0] used_ff;

   logic [CMD_W-1:0]  cmd_ff;
   logic [MAC_W-1:0]  mac_ff;
   logic [ADDR_W-1:0] wanted_ff, caddr_ff;
   logic [IW-1:0]     idx_ff;
   logic              found_ff, free_ok_ff;
   logic              found_fix_ff;
   logic [IW-1:0]     found_idx_ff, free_idx_ff;
   logic [ADDR_W-1:0] exp_ff, cand_ff;
   logic [NW-1:0]     tries_ff;
   logic [VERD_W-1:0] verd_ff;
   logic [ADDR_W-1:0] gr_ff;

   // registered read of current slot
   logic [MAC_W-1:0]  rd_mac_ff;
   logic [ADDR_W-1:0] rd_addr_ff;
   logic              rd_fix_ff;
   logic              rd_used_ff;
   logic [IW-1:0]     rd_idx_ff;
   logic              rd_vld_ff;

   logic [IW-1:0] last_idx;
   assign last_idx = IW'(LEASE_SLOTS - 1);

   always_ff @(posedge clock) begin
      rd_mac_ff  <= mac_mem[idx_ff];
      rd_addr_ff <= addr_mem[idx_ff];
      rd_fix_ff  <= fix_mem[idx_ff];
      rd_used_ff <= used_ff[idx_ff];
      rd_idx_ff  <= idx_ff;
   end

   logic [ADDR_W-1:0] req_addr;
   logic              in_pool, ack, probe_cmd;
   assign req_addr  = (wanted_ff != '0) ? wanted_ff : caddr_ff;
   assign in_pool   = (req_addr >= pool_first) && (req_addr <= pool_last);
   assign probe_cmd = (cmd_ff == CMD_DISCOVER) || (cmd_ff == CMD_REQUEST);

   assign ack     = (req_addr == exp_ff) || ((exp_ff != '0) && in_pool);

   // the scan issues reads one ahead; rd_vld_ff marks a read in flight
   logic rd_hit_mac, rd_hit_addr;
   assign rd_hit_mac  = rd_vld_ff && rd_used_ff && (rd_mac_ff == mac_ff);
   assign rd_hit_addr = rd_vld_ff && rd_used_ff && (rd_addr_ff == cand_ff);

   logic scan_done_ff;

   assign stat.scan_last  = scan_done_ff;
   assign stat.need_walk  = probe_cmd && !found_ff && (pool_first <= pool_last);
   assign stat.probe_hit  = rd_hit_addr;
   assign stat.probe_last = rd_vld_ff && (rd_idx_ff == last_idx);
   assign stat.walk_end   = (cand_ff == pool_last) || (tries_ff == NW'(LEASE_SLOTS));

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         scan_done_ff <= 1'b0;
      end else begin
         scan_done_ff <= 1'b0;
         if (ctrl.load) begin
            cmd_ff     <= req_cmd;
            mac_ff     <= req_mac;
            wanted_ff  <= req_wanted;
            caddr_ff   <= req_caddr;
            idx_ff     <= '0;
            found_ff   <= 1'b0;
            free_ok_ff <= 1'b0;
            exp_ff     <= '0;
            rd_vld_ff  <= 1'b0;
         end
         if (ctrl.scan_step) begin
            rd_vld_ff <= !scan_done_ff && !(rd_vld_ff && rd_idx_ff == last_idx);
            if (idx_ff != last_idx) idx_ff <= idx_ff + 1'b1;
            if (rd_vld_ff) begin
               if (rd_hit_mac && !found_ff) begin
                  found_ff     <= 1'b1;
                  found_idx_ff <= rd_idx_ff;
                  found_fix_ff <= rd_fix_ff;
                  exp_ff       <= rd_addr_ff;
               end
               if (!rd_used_ff && !free_ok_ff) begin
                  free_ok_ff  <= 1'b1;
                  free_idx_ff <= rd_idx_ff;
               end
               if (rd_idx_ff == last_idx) scan_done_ff <= 1'b1;
            end
         end
         if (ctrl.walk_start || ctrl.next_addr) begin
            idx_ff    <= '0;
            rd_vld_ff <= 1'b0;
            if (ctrl.walk_start) begin
               cand_ff  <= pool_first;
               tries_ff <= '0;
            end else begin
               cand_ff  <= cand_ff + 1'b1;
               tries_ff <= tries_ff + 1'b1;
            end
         end
         if (ctrl.probe_step) begin
            rd_vld_ff <= 1'b1;
            if (idx_ff != last_idx) idx_ff <= idx_ff + 1'b1;
            if (rd_hit_addr) begin
               rd_vld_ff <= 1'b0;
            end else if (stat.probe_last) begin
               exp_ff <= cand_ff; // candidate free
            end
         end
         if (ctrl.commit) begin
            verd_ff <= V_DONE;
            gr_ff   <= '0;
            case (cmd_ff)
               CMD_DISCOVER: begin
                  if (exp_ff != '0) begin
                     verd_ff <= V_OFFER;
                     gr_ff   <= exp_ff;
                  end else begin
                     verd_ff <= V_NOADDR;
                  end
               end
               CMD_REQUEST: begin
                  if (ack) begin
                     verd_ff <= V_ACK;
                     gr_ff   <= req_addr;
                     if (!found_ff && free_ok_ff) used_ff[free_idx_ff] <= 1'b1;
                  end else begin
                     verd_ff <= V_NAK;
                  end
               end
               CMD_RELEASE: begin
                  if (found_ff && !found_fix_ff) used_ff[found_idx_ff] <= 1'b0;
               end
               CMD_ADD: begin
                  if (found_ff) begin
                  end else if (free_ok_ff) begin
                     used_ff[free_idx_ff] <= 1'b1;
                  end else begin
                     verd_ff <= V_FULL;
                  end
               end
               CMD_REMOVE: begin
                  if (found_ff) used_ff[found_idx_ff] <= 1'b0;
                  else          verd_ff <= V_NOTFOUND;
               end
               default: ;
            endcase
         end
      end
   end

   // payload writes of the memories
   logic              wr_en;
   logic [IW-1:0]     wr_idx;
   logic [ADDR_W-1:0] wr_addr;
   logic              wr_fix;
   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = free_idx_ff;
      wr_addr = wanted_ff;
      wr_fix  = 1'b1;
      if (ctrl.commit) begin
         if (cmd_ff == CMD_REQUEST && ack && !found_ff && free_ok_ff) begin
            wr_en   = 1'b1;
            wr_addr = req_addr;
            wr_fix  = 1'b0;
         end else if (cmd_ff == CMD_ADD && (found_ff || free_ok_ff)) begin
            wr_en  = 1'b1;
            wr_idx = found_ff ? found_idx_ff : free_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mac_mem[wr_idx]  <= mac_ff;
         addr_mem[wr_idx] <= wr_addr;
         fix_mem[wr_idx]  <= wr_fix;
      end
   end

   assign rsp_verdict = verd_ff;
   assign rsp_granted = gr_ff;

endmodule

@@ rtl/dhcp_lease_table_engine.sv @@
`timescale 1ns / 1ps
// Sequence: an accepted request word starts a slot by slot table scan; a
// discover/request with no lease then walks the pool, and the result is
// committed and offered. Requests are handled one word at a time; the
// single slot read port sets the rate.
// Reset: synchronous, clears lease valid bits, pool registers and control.
// -----------------------------------------------------------------------------
// DHCP lease table engine
// Lease allocator: one controller FSM plus a scanning datapath.
// -----------------------------------------------------------------------------
module dhcp_lease_table_engine
   import dlte_pkg::*;
#(
   parameter int LEASE_SLOTS = 32
) (
   input  logic clock,
   input  logic reset,
   dlte_req_if.sink   req,
   dlte_rsp_if.source rsp,
   dlte_csr_if.sink   csr
);

   ctrl_type ctrl;
   stat_type stat;
   logic [ADDR_W-1:0] pool_first_ff, pool_last_ff;

   // register writes always accepted
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_first_ff <= '0;
         pool_last_ff  <= '0;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_POOL_FIRST: pool_first_ff <= csr.data;
            CSR_POOL_LAST:  pool_last_ff  <= csr.data;
            default: ;
         endcase
      end
   end

   dlte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   dlte_dp #(.LEASE_SLOTS(LEASE_SLOTS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .stat        (stat),
      .req_cmd     (req.cmd),
      .req_mac     (req.client_mac),
      .req_wanted  (req.wanted_addr),
      .req_caddr   (req.cur_addr),
      .pool_first  (pool_first_ff),
      .pool_last   (pool_last_ff),
      .rsp_verdict (rsp.verdict),
      .rsp_granted (rsp.granted_addr)
   );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Lease table engine testbench
// Drives discover, request, release, add-static and remove words through the
// request channel under several pool settings and idle patterns. A local lease
// table model predicts each response, which is checked in order.
// -----------------------------------------------------------------------------
module testbench
   import dlte_pkg::*;
();

   localparam int SLOTS       = 32;
   localparam int DRAIN_WAIT  = 1300;      // worst pool walk plus table scan
   localparam int CYCLE_LIMIT = 6000000;
   localparam int HOLD_LEN    = 2000;
   localparam int MAC_BANK_N  = 40;

   // one request word, with an optional hand-written answer
   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [MAC_W-1:0]  mac;
      logic [ADDR_W-1:0] wanted;
      logic [ADDR_W-1:0] caddr;
      bit                typed;
      logic [VERD_W-1:0] verdict;
      logic [ADDR_W-1:0] granted;
   } lease_cmd_type;

   typedef struct {
      logic [VERD_W-1:0] verdict;
      logic [ADDR_W-1:0] granted;
   } lease_answer_type;

   logic clock;
   logic reset;

   dlte_req_if req ();
   dlte_rsp_if rsp ();
   dlte_csr_if csr ();

   dhcp_lease_table_engine #(.LEASE_SLOTS(SLOTS)) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   // lease table model state
   bit                lease_used [SLOTS];
   logic [MAC_W-1:0]  lease_mac  [SLOTS];
   logic [ADDR_W-1:0] lease_addr [SLOTS];
   bit                lease_fixed[SLOTS];
   logic [ADDR_W-1:0] pool_lo;
   logic [ADDR_W-1:0] pool_hi;

   lease_answer_type  answers_due[$];
   lease_cmd_type     plan[$];
   logic [MAC_W-1:0]  mac_bank[MAC_BANK_N];

   int  send_idle_pct;
   int  stall_pct;
   int  errors;
   int  cycles;
   int  hold_req;
   int  hold_seen;
   int  hold_left;

   // ---------------------------------------------------------------- clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("dhcp_lease_table_engine test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model
   function automatic int slot_of_mac(logic [MAC_W-1:0] mac);
      for (int i = 0; i < SLOTS; i++)
         if (lease_used[i] && lease_mac[i] == mac) return i;
      return -1;
   endfunction

   function automatic int first_free_slot();
      for (int i = 0; i < SLOTS; i++)
         if (!lease_used[i]) return i;
      return -1;
   endfunction

   function automatic bit addr_taken(logic [ADDR_W-1:0] a);
      for (int i = 0; i < SLOTS; i++)
         if (lease_used[i] && lease_addr[i] == a) return 1'b1;
      return 1'b0;
   endfunction

   // address the client would be offered; zero means none
   function automatic logic [ADDR_W-1:0] offer_for(logic [MAC_W-1:0] mac);
      int                s;
      logic [ADDR_W-1:0] a;
      s = slot_of_mac(mac);
      if (s >= 0) return lease_addr[s];
      if (pool_lo > pool_hi) return '0;
      a = pool_lo;
      // walk at most SLOTS+1 candidates, stop at the pool end, no wrap
      for (int n = 0; n <= SLOTS; n++) begin
         if (!addr_taken(a)) return a;
         if (a == pool_hi) break;
         a = a + 1;
      end
      return '0;
   endfunction

   function automatic bit in_pool(logic [ADDR_W-1:0] a);
      return a >= pool_lo && a <= pool_hi;
   endfunction

   // apply one command to the lease table and return the answer
   function automatic lease_answer_type lease_apply(lease_cmd_type c);
      lease_answer_type  r;
      logic [ADDR_W-1:0] want;
      logic [ADDR_W-1:0] e;
      int                s;
      r.verdict = V_DONE;
      r.granted = '0;
      case (c.cmd)
         CMD_DISCOVER: begin
            e = offer_for(c.mac);
            if (e != 0) begin
               r.verdict = V_OFFER;
               r.granted = e;
            end else begin
               r.verdict = V_NOADDR;
            end
         end
         CMD_REQUEST: begin
            want = (c.wanted != 0) ? c.wanted : c.caddr;
            e    = offer_for(c.mac);
            if (want == e || (e != 0 && in_pool(want))) begin
               if (slot_of_mac(c.mac) < 0) begin
                  s = first_free_slot();
                  // full table still acks, stores nothing
                  if (s >= 0) begin
                     lease_used[s]  = 1'b1;
                     lease_mac[s]   = c.mac;
                     lease_addr[s]  = want;
                     lease_fixed[s] = 1'b0;
                  end
               end
               r.verdict = V_ACK;
               r.granted = want;
            end else begin
               r.verdict = V_NAK;
            end
         end
         CMD_RELEASE: begin
            s = slot_of_mac(c.mac);
            if (s >= 0 && !lease_fixed[s]) lease_used[s] = 1'b0;
         end
         CMD_ADD: begin
            s = slot_of_mac(c.mac);
            if (s < 0) begin
               s = first_free_slot();
               if (s >= 0) begin
                  lease_used[s] = 1'b1;
                  lease_mac[s]  = c.mac;
               end
            end
            if (s >= 0) begin
               lease_addr[s]  = c.wanted;
               lease_fixed[s] = 1'b1;
            end else begin
               r.verdict = V_FULL;
            end
         end
         CMD_REMOVE: begin
            s = slot_of_mac(c.mac);
            if (s >= 0) lease_used[s] = 1'b0;
            else r.verdict = V_NOTFOUND;
         end
         default: ;   // unused codes change nothing and answer done
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers
   task automatic csr_write(logic idx, logic [ADDR_W-1:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      @(posedge clock);
      if (idx == CSR_POOL_FIRST) pool_lo = value;
      else pool_hi = value;
   endtask

   // hold the request channel until every response has been checked
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_pool(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
      drain();
      csr_write(CSR_POOL_FIRST, lo);
      csr_write(CSR_POOL_LAST, hi);
   endtask

   // offer one word; predict its answer on acceptance
   task automatic send_word(lease_cmd_type c);
      lease_answer_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.cmd         <= c.cmd;
      req.client_mac  <= c.mac;
      req.wanted_addr <= c.wanted;
      req.cur_addr    <= c.caddr;
      do @(posedge clock); while (!req.ready);
      predicted = lease_apply(c);
      if (c.typed) begin
         predicted.verdict = c.verdict;
         predicted.granted = c.granted;
      end
      answers_due.push_back(predicted);
   endtask

   function automatic lease_cmd_type row(logic [CMD_W-1:0] cmd, logic [MAC_W-1:0] mac,
                                         logic [ADDR_W-1:0] wanted, logic [ADDR_W-1:0] caddr,
                                         bit typed, logic [VERD_W-1:0] v,
                                         logic [ADDR_W-1:0] a);
      lease_cmd_type c;
      c.cmd = cmd;  c.mac = mac;  c.wanted = wanted;  c.caddr = caddr;
      c.typed = typed;  c.verdict = v;  c.granted = a;
      return c;
   endfunction

   function automatic logic [ADDR_W-1:0] pick_in_pool();
      longint span;
      if (pool_lo > pool_hi) return $urandom;
      span = longint'(pool_hi) - longint'(pool_lo) + 1;
      return pool_lo + ADDR_W'(longint'($urandom) % span);
   endfunction

   // mostly well-formed traffic on a small set of clients, some noise
   function automatic lease_cmd_type random_cmd();
      lease_cmd_type c;
      int            roll;
      c.typed   = 1'b0;
      c.verdict = '0;
      c.granted = '0;
      c.mac     = ($urandom_range(9) == 0) ? MAC_W'({$urandom, $urandom}) :
                  mac_bank[$urandom_range(MAC_BANK_N-1)];
      c.wanted  = '0;
      c.caddr   = $urandom;
      roll = $urandom_range(99);
      if (roll < 25) c.cmd = CMD_DISCOVER;
      else if (roll < 55) c.cmd = CMD_REQUEST;
      else if (roll < 70) c.cmd = CMD_RELEASE;
      else if (roll < 82) c.cmd = CMD_ADD;
      else if (roll < 95) c.cmd = CMD_REMOVE;
      else c.cmd = CMD_W'($urandom_range(5, 7));
      roll = $urandom_range(99);
      if (c.cmd == CMD_REQUEST) begin
         // follow up on an offer about half of the time
         if (roll < 40) c.wanted = offer_for(c.mac);
         else if (roll < 65) c.wanted = pick_in_pool();
         else if (roll < 85) c.caddr = ($urandom_range(1) != 0) ? offer_for(c.mac)
                                                                : pick_in_pool();
         else c.wanted = $urandom;
      end else if (c.cmd == CMD_ADD) begin
         c.wanted = (roll < 60) ? pick_in_pool() : $urandom;
      end else if (roll < 30) begin
         c.wanted = $urandom;
      end
      return c;
   endfunction

   // ---------------------------------------------------------------- checker
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         hold_seen <= 0;
         hold_left <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (answers_due.size() == 0) begin
               $error("response with nothing outstanding: verdict %0d addr %h",
                      rsp.verdict, rsp.granted_addr);
               errors = errors + 1;
            end else begin
               lease_answer_type e;
               e = answers_due.pop_front();
               if (rsp.verdict !== e.verdict) begin
                  $error("verdict: expected %0d, got %0d", e.verdict, rsp.verdict);
                  errors = errors + 1;
               end
               if (rsp.granted_addr !== e.granted) begin
                  $error("granted_addr: expected %h, got %h", e.granted, rsp.granted_addr);
                  errors = errors + 1;
               end
            end
         end
         // long hold-off on request, else random stalls
         if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_LEN;
            rsp.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------- main
   logic [ADDR_W-1:0] lo_list[8];
   logic [ADDR_W-1:0] hi_list[8];

   initial begin
      logic [ADDR_W-1:0] lo;
      errors        = 0;
      cycles        = 0;
      hold_req      = 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      pool_lo       = '0;
      pool_hi       = '0;
      for (int i = 0; i < SLOTS; i++) lease_used[i] = 1'b0;
      mac_bank[0] = '0;
      mac_bank[1] = '1;
      for (int i = 2; i < MAC_BANK_N; i++) mac_bank[i] = MAC_W'({$urandom, $urandom});

      req.valid       = 1'b0;
      req.cmd         = '0;
      req.client_mac  = '0;
      req.wanted_addr = '0;
      req.cur_addr    = '0;
      csr.valid       = 1'b0;
      csr.index       = 1'b0;
      csr.data        = '0;
      reset           = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pool settings per phase: small, zero-based, top of range, empty,
      // all zero, short, random, full address space
      lo = $urandom;
      lo_list = '{32'd10, 32'd0, 32'hFFFF_FFE0, 32'd100, 32'd0, 32'd5000, lo, 32'd0};
      hi_list = '{32'd12, 32'd40, 32'hFFFF_FFFF, 32'd99, 32'd0, 32'd5020,
                  (lo > 32'hFFFF_FFC0) ? 32'hFFFF_FFFF : lo + $urandom_range(60),
                  32'hFFFF_FFFF};

      // reset pool is 0..0, which offers nothing
      send_word(row(CMD_DISCOVER, 48'h0000_0000_0001, '0, '0, 1, V_NOADDR, '0));

      for (int ph = 0; ph < 8; ph++) begin
         set_pool(lo_list[ph], hi_list[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 72; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 72; end
            default: begin send_idle_pct = 6; stall_pct = 6; end
         endcase

         if (ph == 0) begin
            // directed: pool 10..12 fills up, then statics and odd codes
            plan.push_back(row(CMD_DISCOVER, 48'hA, '0, '0, 1, V_OFFER, 32'd10));
            plan.push_back(row(CMD_REQUEST, 48'hA, 32'd10, '0, 1, V_ACK, 32'd10));
            plan.push_back(row(CMD_DISCOVER, 48'hB, '0, '0, 0, '0, '0));
            plan.push_back(row(CMD_REQUEST, 48'hB, '0, 32'd11, 0, '0, '0));
            plan.push_back(row(CMD_REQUEST, 48'hC, 32'd12, '0, 0, '0, '0));
            plan.push_back(row(CMD_DISCOVER, 48'hD, '0, '0, 1, V_NOADDR, '0));
            plan.push_back(row(CMD_REQUEST, 48'hD, 32'd5, '0, 1, V_NAK, '0));
            plan.push_back(row(CMD_REQUEST, 48'hA, '0, 32'd10, 0, '0, '0));
            plan.push_back(row(CMD_RELEASE, 48'hA, '0, '0, 1, V_DONE, '0));
            plan.push_back(row(CMD_DISCOVER, '1, '0, '0, 0, '0, '0));
            plan.push_back(row(CMD_ADD, '1, '1, '0, 1, V_DONE, '0));
            plan.push_back(row(CMD_DISCOVER, '1, '0, '0, 0, '0, '0));
            plan.push_back(row(CMD_RELEASE, '1, '0, '0, 1, V_DONE, '0));
            plan.push_back(row(CMD_ADD, '1, 32'd11, '0, 1, V_DONE, '0));
            plan.push_back(row(CMD_REMOVE, '1, '0, '0, 1, V_DONE, '0));
            plan.push_back(row(CMD_REMOVE, '1, '0, '0, 1, V_NOTFOUND, '0));
            plan.push_back(row(CMD_REQUEST, '0, '0, '0, 0, '0, '0));
            plan.push_back(row(CMD_REQUEST, '0, '1, '1, 0, '0, '0));
            plan.push_back(row(3'd5, '1, '1, '1, 1, V_DONE, '0));
            plan.push_back(row(3'd6, '0, '0, '0, 1, V_DONE, '0));
            plan.push_back(row(3'd7, 48'h5555_5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                               1, V_DONE, '0));
            foreach (plan[i]) send_word(plan[i]);
            // fill the table with statics; the adds beyond the free slots report full
            for (int i = 0; i <= SLOTS; i++)
               send_word(row(CMD_ADD, 48'h1000 + i, 32'd20 + i, '0, 0, '0, '0));
            send_word(row(CMD_REQUEST, 48'hEE, '0, 32'd12, 0, '0, '0));
            for (int i = 0; i <= SLOTS; i++)
               send_word(row(CMD_REMOVE, 48'h1000 + i, '0, '0, 0, '0, '0));
         end

         // block fills and stalls its input behind a long receiver hold-off
         if (ph == 5) hold_req = hold_req + 1;

         for (int n = 0; n < 140; n++) begin
            if (ph == 6 && n == 70) drain();
            send_word(random_cmd());
         end
      end

      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0 && answers_due.size() == 0) begin
         $display("dhcp_lease_table_engine test passed");
      end else begin
         $display("dhcp_lease_table_engine test failed");
      end
      $finish;
   end

endmodule
